// ----- rtl/core/sat_pkg.sv -----
// shared types and constants for the seen address table
package sat_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RES_W = $clog2(MAX_RESULTS + 1);
  localparam logic [31:0] STALE_RESET = 32'd60000;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_LIST   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC_SCAN,
    ST_REC_WR,
    ST_LIST_SCAN,
    ST_LIST_EVAL,
    ST_LIST_END
  } state_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [31:0]       now_ms;
    logic [47:0]       peer_addr;
    logic [1:0]        peer_addr_type;
    logic signed [7:0] peer_rssi;
    logic [63:0]       uuid_high;
    logic [63:0]       uuid_low;
    logic [4:0]        list_limit;
  } item_t;

  typedef struct packed {
    logic              has_entry;
    logic [47:0]       out_addr;
    logic [1:0]        out_addr_type;
    logic signed [7:0] out_rssi;
    logic [31:0]       out_seen_ms;
    logic [63:0]       out_uuid_high;
    logic [63:0]       out_uuid_low;
    logic              is_last;
  } result_t;

  typedef struct packed {
    logic [47:0]       addr;
    logic [1:0]        addr_type;
    logic signed [7:0] rssi;
    logic [31:0]       seen_ms;
    logic [63:0]       uuid_high;
    logic [63:0]       uuid_low;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             inval_en;
    logic [IDX_W-1:0] inval_addr;
    logic             clr_all;
  } store_req_t;

endpackage

// ----- rtl/core/sat_if.sv -----
// valid/ready channels for items and results
interface sat_item_if;
  import sat_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sat_result_if;
  import sat_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/sat_store.sv -----
// entry memory with registered read data and per-entry valid flops
module sat_store (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sat_pkg::store_req_t            req_i,
  input  sat_pkg::entry_t                wr_data_i,
  output sat_pkg::entry_t                rd_data_o,
  output logic [sat_pkg::TABLE_DEPTH-1:0] valid_o
);
  import sat_pkg::*;

  entry_t                 mem_q [TABLE_DEPTH];
  entry_t                 rd_data_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [TABLE_DEPTH-1:0] valid_d;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= wr_data_i;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (req_i.inval_en) begin
      valid_d[req_i.inval_addr] = 1'b0;
    end
    if (req_i.wr_en) begin
      valid_d[req_i.wr_addr] = 1'b1;
    end
    if (req_i.clr_all) begin
      valid_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign rd_data_o = rd_data_q;
  assign valid_o   = valid_q;

endmodule

// ----- rtl/core/seen_address_table.sv -----
// top level of the seen address table: sequencer around the entry memory
//
//   channel    dir  handshake     payload
//   item_i     in   valid/ready   opcode, now_ms, peer fields, uuid, list_limit
//   result_o   out  valid/ready   has_entry, entry fields, is_last
//   cfg        in   cfg_we_i      cfg_wdata_i -> stale_age_ms
//
// record: one memory read per entry then one write
// list: one read per live entry until the limit is reached, on the single read port
// clear: reset clears the valid flops at once, no sweep
// item_i is ready only between transactions; a full result register stalls the list walk
module seen_address_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  sat_item_if.sink    item_i,
  sat_result_if.source result_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);
  import sat_pkg::*;

  state_e                 state_q, state_d;
  item_t                  item_q;
  logic [31:0]            stale_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [RES_W-1:0]       n_q, limit_q;
  logic                   ev_vld_q;
  logic [IDX_W-1:0]       ev_idx_q;
  logic                   hit_q, free_q, old_q;
  logic [IDX_W-1:0]       hit_idx_q, free_idx_q, old_idx_q;
  logic [31:0]            old_ms_q;
  entry_t                 pend_q;
  logic                   pend_vld_q;
  result_t                out_q;
  logic                   out_vld_q;

  store_req_t             req;
  entry_t                 wr_data, rd_data;
  logic [TABLE_DEPTH-1:0] valid;
  result_t                empty_row;

  logic                   accept, out_free, cnt_end, live_cur, stale;
  logic                   take_pend, push_mid, push_end;
  logic [IDX_W-1:0]       idx;
  logic                   ev_valid, ev_match;
  logic [31:0]            age, old_diff;

  sat_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data),
    .valid_o   (valid)
  );

  assign accept   = item_i.valid && item_i.ready;
  assign out_free = !out_vld_q || result_o.ready;
  assign idx      = cnt_q[IDX_W-1:0];
  assign cnt_end  = (cnt_q == CNT_W'(TABLE_DEPTH));
  assign live_cur = valid[idx] && (n_q < limit_q);
  // wrap-aware age against the item's time
  assign age      = item_q.now_ms - rd_data.seen_ms;
  assign stale    = age > stale_q;
  assign ev_valid = valid[ev_idx_q];
  assign ev_match = ev_valid && (rd_data.addr == item_q.peer_addr);
  assign old_diff = rd_data.seen_ms - old_ms_q;

  assign wr_data.addr      = item_q.peer_addr;
  assign wr_data.addr_type = item_q.peer_addr_type;
  assign wr_data.rssi      = item_q.peer_rssi;
  assign wr_data.seen_ms   = item_q.now_ms;
  assign wr_data.uuid_high = item_q.uuid_high;
  assign wr_data.uuid_low  = item_q.uuid_low;

  // lone closing transaction of a list that found nothing
  always_comb begin
    empty_row         = '0;
    empty_row.is_last = 1'b1;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(item_i.data.opcode))
            OP_RECORD: state_d = ST_REC_SCAN;
            OP_LIST:   state_d = ST_LIST_SCAN;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_REC_SCAN: begin
        if (ev_vld_q && (ev_idx_q == IDX_W'(TABLE_DEPTH - 1))) begin
          state_d = ST_REC_WR;
        end
      end
      ST_REC_WR: state_d = ST_IDLE;
      ST_LIST_SCAN: begin
        if (cnt_end) begin
          state_d = ST_LIST_END;
        end else if (live_cur) begin
          state_d = ST_LIST_EVAL;
        end
      end
      ST_LIST_EVAL: begin
        if (stale || !pend_vld_q || out_free) begin
          state_d = ST_LIST_SCAN;
        end
      end
      ST_LIST_END: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req          = '0;
    item_i.ready = 1'b0;
    take_pend    = 1'b0;
    push_end     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        item_i.ready = 1'b1;
        req.clr_all  = accept && (op_e'(item_i.data.opcode) == OP_CLEAR);
      end
      ST_REC_SCAN: begin
        req.rd_en   = !cnt_end;
        req.rd_addr = idx;
      end
      ST_REC_WR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = hit_q ? hit_idx_q : (free_q ? free_idx_q : old_idx_q);
      end
      ST_LIST_SCAN: begin
        req.rd_en   = !cnt_end && live_cur;
        req.rd_addr = idx;
      end
      ST_LIST_EVAL: begin
        req.inval_en   = stale;
        req.inval_addr = idx;
        take_pend      = !stale && (!pend_vld_q || out_free);
      end
      ST_LIST_END: begin
        push_end = out_free;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  assign push_mid = take_pend && pend_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      stale_q    <= STALE_RESET;
      cnt_q      <= '0;
      n_q        <= '0;
      limit_q    <= '0;
      ev_vld_q   <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      old_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        stale_q <= cfg_wdata_i;
      end
      if (accept) begin
        cnt_q      <= '0;
        n_q        <= '0;
        limit_q    <= (item_i.data.list_limit > 5'(MAX_RESULTS)) ?
                      RES_W'(MAX_RESULTS) : RES_W'(item_i.data.list_limit);
        ev_vld_q   <= 1'b0;
        hit_q      <= 1'b0;
        free_q     <= 1'b0;
        old_q      <= 1'b0;
        pend_vld_q <= 1'b0;
      end
      if (state_q == ST_REC_SCAN) begin
        ev_vld_q <= !cnt_end;
        if (!cnt_end) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (ev_vld_q) begin
          if (ev_match && !hit_q) begin
            hit_q <= 1'b1;
          end
          if (!ev_valid && !free_q) begin
            free_q <= 1'b1;
          end
          // oldest by signed time difference, lowest index wins ties
          if (ev_valid && !ev_match && (!old_q || old_diff[31])) begin
            old_q <= 1'b1;
          end
        end
      end
      if ((state_q == ST_LIST_SCAN) && !cnt_end && !live_cur) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if ((state_q == ST_LIST_EVAL) && (stale || take_pend)) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (take_pend) begin
        pend_vld_q <= 1'b1;
        n_q        <= n_q + 1'b1;
      end
      if (push_end) begin
        pend_vld_q <= 1'b0;
      end
      if (push_mid || push_end) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i.data;
    end
    if (state_q == ST_REC_SCAN) begin
      ev_idx_q <= idx;
      if (ev_vld_q) begin
        if (ev_match && !hit_q) begin
          hit_idx_q <= ev_idx_q;
        end
        if (!ev_valid && !free_q) begin
          free_idx_q <= ev_idx_q;
        end
        if (ev_valid && !ev_match && (!old_q || old_diff[31])) begin
          old_idx_q <= ev_idx_q;
          old_ms_q  <= rd_data.seen_ms;
        end
      end
    end
    if (take_pend) begin
      pend_q <= rd_data;
    end
    if (push_mid || push_end) begin
      if (push_end && !pend_vld_q) begin
        out_q <= empty_row;
      end else begin
        out_q.has_entry     <= 1'b1;
        out_q.out_addr      <= pend_q.addr;
        out_q.out_addr_type <= pend_q.addr_type;
        out_q.out_rssi      <= pend_q.rssi;
        out_q.out_seen_ms   <= pend_q.seen_ms;
        out_q.out_uuid_high <= pend_q.uuid_high;
        out_q.out_uuid_low  <= pend_q.uuid_low;
        out_q.is_last       <= push_end;
      end
    end
  end

  assign result_o.valid = out_vld_q;
  assign result_o.data  = out_q;

endmodule
